@@ sv/upd_pkg.sv @@
// Shared types, constants and hex helpers for the URL percent decoder.
`default_nettype none
package upd_pkg;

  localparam logic [7:0] PCT_CHAR = 8'h25;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       string_last;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_end;
  } out_word_t;

  // Up to three output bytes produced by one input word.
  typedef struct packed {
    logic [1:0] cnt;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic       last;
  } cmd_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_PCT  = 3'b010,
    PH_DIG  = 3'b100
  } phase_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) ||
           (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  // Nibble value of a character already known to be a hex digit.
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] lc;
    lc = c | 8'h20;
    if (c <= 8'h39) begin
      return c[3:0];
    end
    return 4'(lc - 8'h61 + 8'd10);
  endfunction

endpackage
`default_nettype wire

@@ sv/url_percent_decoder_top.sv @@
// Top level of the URL percent decoder: front end, command queue, byte serializer.
// Accepts one encoded byte per cycle while full is low and replaces each valid
// percent escape with the byte it encodes; an input word yields zero to three
// output words. The front end classifies a word in the cycle it is pushed and
// writes a command to a QUEUE_DEPTH-entry queue; the back end drains one output
// byte per cycle while the output register is free or popped, so the input keeps
// accepting words while earlier commands still drain, and full rises when the
// queue fills. A byte passes through a queue entry and the output register.
`default_nettype none
module url_percent_decoder_top
  import upd_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  output logic           full,
  input  wire in_word_t  in_word,
  output logic           empty,
  input  wire logic      pop,
  output out_word_t      out_word
);

  cmd_t fr_cmd, q_head;
  logic fr_push, q_vld, q_pop;

  upd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (push && !full),
    .in_w     (in_word),
    .cmd      (fr_cmd),
    .cmd_push (fr_push)
  );

  upd_cmd_fifo #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (fr_push),
    .wdata (fr_cmd),
    .rd    (q_pop),
    .rdata (q_head),
    .full  (full),
    .vld   (q_vld)
  );

  upd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (q_head),
    .head_vld (q_vld),
    .head_pop (q_pop),
    .pop      (pop),
    .empty    (empty),
    .out_w    (out_word)
  );

endmodule
`default_nettype wire

@@ sv/upd_front.sv @@
// Front end: tracks the escape state; an input word yields a byte command or none.
`default_nettype none
module upd_front
  import upd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     acc,
  input  wire in_word_t in_w,
  output cmd_t          cmd,
  output logic          cmd_push
);

  phase_t     phase_r, phase_nxt;
  logic [7:0] held_r, held_nxt;
  logic       hx, pct, last;
  logic [7:0] b;

  always_comb begin
    b    = in_w.in_byte;
    last = in_w.string_last;
    hx   = is_hex(b);
    pct  = (b == PCT_CHAR);
    cmd       = '0;
    cmd.last  = last;
    phase_nxt = phase_r;
    held_nxt  = held_r;
    unique case (phase_r)
      PH_PCT: begin
        if (hx && last) begin
          cmd.cnt = 2'd2; cmd.b0 = PCT_CHAR; cmd.b1 = b;
          phase_nxt = PH_IDLE;
        end else if (hx) begin
          held_nxt  = b;
          phase_nxt = PH_DIG;
        end else if (pct && !last) begin
          // broken escape, the breaking byte opens a new one
          cmd.cnt = 2'd1; cmd.b0 = PCT_CHAR;
          phase_nxt = PH_PCT;
        end else begin
          cmd.cnt = 2'd2; cmd.b0 = PCT_CHAR; cmd.b1 = b;
          phase_nxt = PH_IDLE;
        end
      end
      PH_DIG: begin
        if (hx) begin
          cmd.cnt = 2'd1;
          cmd.b0  = {hex_value(held_r), hex_value(b)};
          phase_nxt = PH_IDLE;
        end else if (pct && !last) begin
          cmd.cnt = 2'd2; cmd.b0 = PCT_CHAR; cmd.b1 = held_r;
          phase_nxt = PH_PCT;
        end else begin
          cmd.cnt = 2'd3; cmd.b0 = PCT_CHAR; cmd.b1 = held_r; cmd.b2 = b;
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        if (pct && !last) begin
          phase_nxt = PH_PCT;
        end else begin
          cmd.cnt = 2'd1; cmd.b0 = b;
          phase_nxt = PH_IDLE;
        end
      end
    endcase
    if (last) begin
      phase_nxt = PH_IDLE;
      held_nxt  = '0;
    end
  end

  assign cmd_push = acc && (cmd.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else if (acc) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (acc) begin
      held_r <= held_nxt;
    end
  end

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_w.string_last |=> phase_r == PH_IDLE)
    else $error("phase not cleared after final byte");
  a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_w.string_last |-> cmd_push)
    else $error("final byte produced no output");

endmodule
`default_nettype wire

@@ sv/upd_cmd_fifo.sv @@
// Short command queue between the front end and the byte serializer.
`default_nettype none
module upd_cmd_fifo
  import upd_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr,
  input  wire cmd_t wdata,
  input  wire logic rd,
  output cmd_t      rdata,
  output logic      full,
  output logic      vld
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

  cmd_t          mem_r [DEPTH];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_wr, do_rd;

  assign full  = (cnt_r == CW'(DEPTH));
  assign vld   = (cnt_r != '0);
  assign rdata = mem_r[rp_r];
  assign do_wr = wr && !full;
  assign do_rd = rd && vld;

  always_comb begin
    wp_nxt  = do_wr ? ((wp_r == LAST_PTR) ? '0 : wp_r + 1'b1) : wp_r;
    rp_nxt  = do_rd ? ((rp_r == LAST_PTR) ? '0 : rp_r + 1'b1) : rp_r;
    cnt_nxt = cnt_r + CW'(do_wr) - CW'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wdata;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr |-> !full)
    else $error("write into full command queue");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("command queue count out of range");

endmodule
`default_nettype wire

@@ sv/upd_back.sv @@
// Back end: drains one command byte per cycle into the output register while it is empty or popped.
`default_nettype none
module upd_back
  import upd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire cmd_t head,
  input  wire logic head_vld,
  output logic      head_pop,
  input  wire logic pop,
  output logic      empty,
  output out_word_t out_w
);

  logic [1:0] idx_r, idx_nxt;
  logic       out_vld_r, out_vld_nxt;
  out_word_t  out_r, word_nxt;
  logic       load, run_end;

  assign load    = head_vld && (!out_vld_r || pop);
  assign run_end = (idx_r == head.cnt - 2'd1);
  assign head_pop = load && run_end;

  always_comb begin
    word_nxt = '0;
    unique case (idx_r)
      2'd0:    word_nxt.out_byte = head.b0;
      2'd1:    word_nxt.out_byte = head.b1;
      default: word_nxt.out_byte = head.b2;
    endcase
    word_nxt.run_last   = run_end;
    word_nxt.string_end = run_end && head.last;
    idx_nxt     = load ? (run_end ? 2'd0 : idx_r + 2'd1) : idx_r;
    out_vld_nxt = load || (out_vld_r && !pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      idx_r     <= idx_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= word_nxt;
    end
  end

  assign empty = !out_vld_r;
  assign out_w = out_r;

  a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    head_vld |-> idx_r < head.cnt)
    else $error("byte index past end of command");
  a_end_on_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_r.string_end |-> out_r.run_last)
    else $error("string end not on last byte of run");

endmodule
`default_nettype wire

@@ sim/url_percent_decoder_top_tb.sv @@
// Self-checking testbench for url_percent_decoder_top: directed and random strings.
import upd_pkg::*;

class decode_scoreboard;
  out_word_t  pending_bytes[$];
  out_word_t  burst[$];
  phase_t     phase = PH_IDLE;
  logic [7:0] held = 8'h00;
  int         errors = 0;

  function bit is_hex_digit(logic [7:0] c);
    return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
  endfunction

  function logic [3:0] nibble_of(logic [7:0] c);
    if (c < 8'h41) return 4'(c - 8'h30);
    if (c < 8'h61) return 4'(c - 8'h37);
    return 4'(c - 8'h57);
  endfunction

  function void emit(logic [7:0] b);
    out_word_t w;
    w.out_byte = b;
    w.run_last = 1'b0;
    w.string_end = 1'b0;
    burst.push_back(w);
  endfunction

  // Look at a byte with nothing held; a percent sign starts an escape unless it ends the string.
  function void start_fresh(logic [7:0] b, logic last);
    if (b == PCT_CHAR && !last) begin
      phase = PH_PCT;
    end else begin
      phase = PH_IDLE;
      emit(b);
    end
  endfunction

  function void note_input(in_word_t w);
    logic [7:0] b;
    logic       last;
    b = w.in_byte;
    last = w.string_last;
    burst.delete();
    case (phase)
      PH_PCT: begin
        if (is_hex_digit(b)) begin
          if (last) begin
            emit(PCT_CHAR);
            emit(b);
          end else begin
            held = b;
            phase = PH_DIG;
          end
        end else begin
          emit(PCT_CHAR);
          start_fresh(b, last);
        end
      end
      PH_DIG: begin
        if (is_hex_digit(b)) begin
          emit({nibble_of(held), nibble_of(b)});
          phase = PH_IDLE;
        end else begin
          emit(PCT_CHAR);
          emit(held);
          start_fresh(b, last);
        end
      end
      default: start_fresh(b, last);
    endcase
    if (last) begin
      phase = PH_IDLE;
      held = 8'h00;
    end
    if (burst.size() > 0) begin
      burst[burst.size() - 1].run_last = 1'b1;
      burst[burst.size() - 1].string_end = last;
    end
    foreach (burst[i]) pending_bytes.push_back(burst[i]);
  endfunction

  function void check_output(out_word_t got);
    out_word_t want;
    if (pending_bytes.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected word: byte %h run_last %b string_end %b",
                 got.out_byte, got.run_last, got.string_end);
      return;
    end
    want = pending_bytes.pop_front();
    if (got.out_byte !== want.out_byte || got.run_last !== want.run_last ||
        got.string_end !== want.string_end) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: expected byte %h run_last %b string_end %b, got %h %b %b",
                 want.out_byte, want.run_last, want.string_end,
                 got.out_byte, got.run_last, got.string_end);
    end
  endfunction
endclass

module url_percent_decoder_top_tb;
  localparam int STALL_LIMIT = 3000;
  localparam int RANDOM_WORDS = 150;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      push = 1'b0;
  logic      pop = 1'b0;
  in_word_t  in_word = '0;
  logic      full;
  logic      empty;
  out_word_t out_word;

  decode_scoreboard sb = new();
  bit          steady = 1'b0;
  int unsigned stuck = 0;
  int unsigned words_sent = 0;

  url_percent_decoder_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .push(push),
    .full(full),
    .in_word(in_word),
    .empty(empty),
    .pop(pop),
    .out_word(out_word)
  );

  always #6 clk = ~clk;

  // End the run if no word moves on either side for too long.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) begin
      stuck <= 0;
    end else if (stuck == STALL_LIMIT) begin
      $display("url_percent_decoder_top_tb NOT OK");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  function int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function logic [7:0] pick_char();
    string       hex_set;
    string       edge_set;
    int unsigned r;
    hex_set = "0123456789abcdefABCDEF";
    edge_set = "/:@G`g";
    r = $urandom_range(0, 99);
    if (r < 25) return PCT_CHAR;
    if (r < 55) return hex_set[$urandom_range(0, 21)];
    if (r < 70) return edge_set[$urandom_range(0, 5)];
    return 8'($urandom_range(0, 255));
  endfunction

  function logic [7:0] pick_hex();
    string hex_set;
    hex_set = "0123456789abcdefABCDEF";
    return hex_set[$urandom_range(0, 21)];
  endfunction

  // Hold push until the word is taken; leave push high so the next word can follow at once.
  task automatic send_word(input logic [7:0] b, input logic last);
    int unsigned gap;
    in_word_t    w;
    w.in_byte = b;
    w.string_last = last;
    gap = pick_gap();
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (full);
    sb.note_input(w);
    words_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], i == s.len() - 1);
  endtask

  // Well-formed escapes with random content, some broken ones and noise.
  task automatic send_random_string();
    logic [7:0] text[$];
    int         n;
    n = $urandom_range(1, 8);
    while (text.size() < n) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          text.push_back(PCT_CHAR);
          text.push_back(pick_hex());
          text.push_back(pick_hex());
        end
        4: begin
          text.push_back(PCT_CHAR);
          text.push_back(pick_hex());
        end
        default: text.push_back(pick_char());
      endcase
    end
    foreach (text[i]) send_word(text[i], i == text.size() - 1);
  endtask

  task automatic drain_results();
    push <= 1'b0;
    @(posedge clk);
    while (sb.pending_bytes.size() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned stall;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = pick_gap();
      if (stall != 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      sb.check_output(out_word);
    end
  end

  initial begin
    int strings_sent;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_text("%41");
    send_text("a%2");
    send_text("%4z");
    send_text("%");
    send_text("%%41");
    send_text("%fA");
    send_text("%0g");
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(PCT_CHAR, 1'b0);
    send_word(8'hC1, 1'b0);
    send_word(8'hFF, 1'b1);

    strings_sent = 0;
    while (words_sent < RANDOM_WORDS) begin
      if (strings_sent == 6) drain_results();
      steady = (strings_sent >= 12 && strings_sent < 18);
      send_random_string();
      strings_sent++;
    end
    steady = 1'b0;

    drain_results();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending_bytes.size() == 0) begin
      $display("url_percent_decoder_top_tb OK");
    end else begin
      $display("url_percent_decoder_top_tb NOT OK");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
sv/upd_pkg.sv
sv/upd_front.sv
sv/upd_cmd_fifo.sv
sv/upd_back.sv
sv/url_percent_decoder_top.sv
sim/url_percent_decoder_top_tb.sv
